@@ hdl/smf_pkg.sv @@
`timescale 1ns / 1ps

package smf_pkg;

  // sample and median width in bits (values in millimetres)
  localparam int unsigned SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // flags handed from one cell to the next in the same cycle
  typedef struct packed {
    logic valid;     // compacted entry holds a sample
    logic gt;        // compacted entry sorts after the new sample
    logic del_seen;  // the expiring entry sits at or left of this cell
  } smf_link_t;

endpackage

@@ hdl/sliding_median_filter.sv @@
`timescale 1ns / 1ps

// Sliding-window median over the last WINDOW_DEPTH samples. The window is a
// row of cells kept in ascending order; each cell tracks the age of its
// sample, so the oldest one leaves and the new one drops into place in one
// pass along the row. The filter takes one word per cycle while its result is
// not stalled and answers each word in the cycle after it is accepted, with
// the middle element of the held samples (the upper median while the count is
// even). Throughput is set by the single compare-and-shift step of the cell
// row; a stalled result holds the input off until it is taken.
module sliding_median_filter #(
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smf_pkg::sample_t    in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output smf_pkg::sample_t    out_median_value
);

  localparam int unsigned AGE_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic                 accept;
  logic                 full;
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     fill_nxt;
  logic [AGE_W-1:0]     mid_r;
  logic                 out_valid_r;

  smf_pkg::smf_link_t   link      [WINDOW_DEPTH];
  smf_pkg::sample_t     c_value   [WINDOW_DEPTH];
  logic [AGE_W-1:0]     c_age     [WINDOW_DEPTH];
  logic                 valid_r   [WINDOW_DEPTH];
  smf_pkg::sample_t     value_r   [WINDOW_DEPTH];
  logic [AGE_W-1:0]     age_r     [WINDOW_DEPTH];

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (fill_r == CNT_W'(WINDOW_DEPTH));
  assign fill_nxt  = full ? fill_r : fill_r + CNT_W'(1);
  assign out_valid = out_valid_r;

  // build the sorted cell row
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    smf_pkg::smf_link_t left_link;
    smf_pkg::sample_t   left_value;
    logic [AGE_W-1:0]   left_age;
    logic               right_valid;
    smf_pkg::sample_t   right_value;
    logic [AGE_W-1:0]   right_age;

    if (k == 0) begin : g_head
      assign left_link  = '0;
      assign left_value = '0;
      assign left_age   = '0;
    end else begin : g_body
      assign left_link  = link[k-1];
      assign left_value = c_value[k-1];
      assign left_age   = c_age[k-1];
    end

    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_age   = '0;
    end else begin : g_inner
      assign right_valid = valid_r[k+1];
      assign right_value = value_r[k+1];
      assign right_age   = age_r[k+1];
    end

    smf_cell #(
      .DEPTH (WINDOW_DEPTH),
      .AGE_W (AGE_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (accept),
      .full        (full),
      .sample      (in_sample),
      .left_link   (left_link),
      .left_value  (left_value),
      .left_age    (left_age),
      .right_valid (right_valid),
      .right_value (right_value),
      .right_age   (right_age),
      .valid_r     (valid_r[k]),
      .value_r     (value_r[k]),
      .age_r       (age_r[k]),
      .link        (link[k]),
      .c_value     (c_value[k]),
      .c_age       (c_age[k])
    );
  end

  // advance fill count and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the middle position for the pending word
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_r <= AGE_W'(fill_nxt >> 1);
    end
  end

  // pick the median from the sorted row
  assign out_median_value = value_r[mid_r];

endmodule

@@ hdl/smf_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted window: holds a sample, its age and a valid bit.
module smf_cell #(
  parameter int unsigned DEPTH = 5,
  parameter int unsigned AGE_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic                full,
  input  smf_pkg::sample_t    sample,
  // compacted entry of the left neighbor
  input  smf_pkg::smf_link_t  left_link,
  input  smf_pkg::sample_t    left_value,
  input  logic [AGE_W-1:0]    left_age,
  // stored entry of the right neighbor
  input  logic                right_valid,
  input  smf_pkg::sample_t    right_value,
  input  logic [AGE_W-1:0]    right_age,
  // stored entry of this cell
  output logic                valid_r,
  output smf_pkg::sample_t    value_r,
  output logic [AGE_W-1:0]    age_r,
  // compacted entry of this cell, toward the right neighbor
  output smf_pkg::smf_link_t  link,
  output smf_pkg::sample_t    c_value,
  output logic [AGE_W-1:0]    c_age
);

  logic             del;
  logic             valid_nxt;
  smf_pkg::sample_t value_nxt;
  logic [AGE_W-1:0] age_nxt;

  // drop the oldest entry once the window is full
  assign del = full && valid_r && (age_r == AGE_W'(DEPTH - 1));

  // close the gap left by the dropped entry
  always_comb begin
    link.del_seen = left_link.del_seen | del;
    if (link.del_seen) begin
      link.valid = right_valid;
      c_value    = right_value;
      c_age      = right_age;
    end else begin
      link.valid = valid_r;
      c_value    = value_r;
      c_age      = age_r;
    end
    link.gt = !link.valid || (c_value > sample);
  end

  // insert the new sample where the order first exceeds it
  always_comb begin
    if (left_link.gt) begin
      valid_nxt = left_link.valid;
      value_nxt = left_value;
      age_nxt   = left_age + AGE_W'(1);
    end else if (link.gt) begin
      valid_nxt = 1'b1;
      value_nxt = sample;
      age_nxt   = '0;
    end else begin
      valid_nxt = link.valid;
      value_nxt = c_value;
      age_nxt   = c_age + AGE_W'(1);
    end
  end

  // hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= valid_nxt;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH       = 5;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;

  // partial fill, extremes, wraparound, ties, and alternating bit patterns
  localparam smf_pkg::sample_t EDGE_SAMPLES [22] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555,
    16'h04D2, 16'h04D2, 16'h10E1, 16'h04D2, 16'hFFFE,
    16'h0002, 16'h04D2
  };

  // Median predictor: circular window, fill count and the medians still owed
  class median_board;
    smf_pkg::sample_t window_mem [DEPTH];
    int unsigned      wr_ptr;
    int unsigned      fill_cnt;
    smf_pkg::sample_t median_q [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      noted;

    function new();
      wr_ptr   = 0;
      fill_cnt = 0;
      errors   = 0;
      checked  = 0;
      noted    = 0;
    endfunction

    // Store the sample, advance the window and queue the median it yields
    function void note_sample(smf_pkg::sample_t s);
      smf_pkg::sample_t held [DEPTH];
      smf_pkg::sample_t v;
      int unsigned      i;
      int unsigned      j;
      window_mem[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
      if (fill_cnt < DEPTH) fill_cnt++;
      for (i = 0; i < fill_cnt; i++) held[i] = window_mem[i];
      // ascending insertion sort over the written entries only
      for (i = 1; i < fill_cnt; i++) begin
        v = held[i];
        j = i;
        while (j > 0 && held[j-1] > v) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = v;
      end
      median_q.push_back(held[fill_cnt / 2]);
      noted++;
    endfunction

    // Compare a delivered median with the oldest one owed
    function void check_median(smf_pkg::sample_t got);
      smf_pkg::sample_t want;
      if (median_q.size() == 0) begin
        $error("median_value: no sample waiting, got %0d", got);
        errors++;
      end else begin
        want = median_q.pop_front();
        checked++;
        if (want !== got) begin
          $error("median_value: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return median_q.size();
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  smf_pkg::sample_t in_sample = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  smf_pkg::sample_t out_median_value;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  median_board board = new();

  sliding_median_filter #(
    .WINDOW_DEPTH(DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median_value(out_median_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both channels; note inputs before checking results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_sample(in_sample);
      if (out_valid && !out_stall) board.check_median(out_median_value);
    end
  end

  // Drive the output stall: a counted long hold when requested, else random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abort the run, as a mismatch, once it passes the cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sliding_median_filter: mismatch");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic push_sample(input smf_pkg::sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Mix full-range values with clustered ones so ties and extremes recur
  function automatic smf_pkg::sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(3);
    case (pick)
      0: return smf_pkg::sample_t'($urandom);
      1: return smf_pkg::sample_t'($urandom_range(7));
      2: return smf_pkg::sample_t'(16'hFFFF - $urandom_range(3));
      default: return smf_pkg::sample_t'(16'h8000 + $urandom_range(8) - 4);
    endcase
  endfunction

  task automatic push_random(input int unsigned count);
    repeat (count) push_sample(random_sample());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: filling window, full-window wrap, equal samples, extremes
    foreach (EDGE_SAMPLES[i]) push_sample(EDGE_SAMPLES[i]);

    // sender idles lightly, receiver heavily; open with a long output hold
    send_idle_pct = 26;
    recv_idle_pct = 57;
    hold_left     = HOLD_CYCLES;
    push_random(200);

    // swap the idle rates
    send_idle_pct = 57;
    recv_idle_pct = 26;
    push_random(200);

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(180);

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then idle before the summary
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d samples through a %0d-deep window; %0d medians checked,",
             board.noted, DEPTH, board.checked);
    $display("covering fill-up, wraparound, ties, extremes and a long output hold.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("sliding_median_filter: match");
    end else begin
      $display("sliding_median_filter: mismatch");
    end
    $finish;
  end

endmodule
